// File: rtl/wgma_pkg.sv
// Package with shared types and constants of the weighted Gram matrix accumulator.
package wgma_pkg;

  localparam int COEF_NUM      = 8;
  localparam int MAX_COEFS_DEF = 8;
  localparam int DESIGN_W      = 16;
  localparam int WEIGHT_W      = 32;
  localparam int SUM_W         = 64;
  localparam int NCOEF_W       = 4;
  localparam int POS_W         = 3;
  localparam int QDEPTH        = 2;

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  // One accepted sample word, tagged with the active coefficient count.
  typedef struct packed {
    logic [WEIGHT_W-1:0]              weight;
    logic [COEF_NUM-1:0][DESIGN_W-1:0] xval;
    logic                             last;
    logic [NCOEF_W-1:0]               ncoef;
  } item_t;

  // Queue head as seen by the back end.
  typedef struct packed {
    logic  valid;
    item_t item;
  } qhead_t;

endpackage

// File: rtl/wgma_if.sv
// Channel interfaces for sample words and matrix entry words.
interface wgma_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] weight;
  logic signed [15:0] design_0;
  logic signed [15:0] design_1;
  logic signed [15:0] design_2;
  logic signed [15:0] design_3;
  logic signed [15:0] design_4;
  logic signed [15:0] design_5;
  logic signed [15:0] design_6;
  logic signed [15:0] design_7;
  logic        last_sample;

  modport source (output valid, weight, design_0, design_1, design_2, design_3,
                  design_4, design_5, design_6, design_7, last_sample,
                  input ready);
  modport sink (input valid, weight, design_0, design_1, design_2, design_3,
                design_4, design_5, design_6, design_7, last_sample,
                output ready);
endinterface

interface wgma_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  row_index;
  logic [2:0]  col_index;
  logic signed [63:0] sum_value;
  logic        last_entry;

  modport source (output valid, row_index, col_index, sum_value, last_entry,
                  input ready);
  modport sink (input valid, row_index, col_index, sum_value, last_entry,
                output ready);
endinterface

// File: rtl/wgma_ram.sv
// Generic single-write, single-read RAM with registered read data.
module wgma_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 36,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                   clk,
  input  logic                   we,
  input  logic [AW-1:0]          waddr,
  input  logic [WIDTH-1:0]       wdata,
  input  logic                   re,
  input  logic [AW-1:0]          raddr,
  output logic [WIDTH-1:0]       rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// File: rtl/wgma_front.sv
// Front end: coefficient count register, sample intake and the sample queue.
module wgma_front import wgma_pkg::*; #(
  parameter int MAX_COEFS = MAX_COEFS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [NCOEF_W-1:0] cfg_wdata,
  wgma_in_if.sink            in_ch,
  output qhead_t             head,
  input  logic               pop
);
  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W = $clog2(QDEPTH + 1);

  logic [NCOEF_W-1:0] num_coefs_r;
  logic [NCOEF_W-1:0] ncoef_cl;
  item_t              q_mem_r [QDEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               push;
  item_t              new_item;

  // Out-of-range counts are clamped when the sample is taken.
  always_comb begin
    if (num_coefs_r == '0) begin
      ncoef_cl = NCOEF_W'(1);
    end else if (num_coefs_r > NCOEF_W'(MAX_COEFS)) begin
      ncoef_cl = NCOEF_W'(MAX_COEFS);
    end else begin
      ncoef_cl = num_coefs_r;
    end
  end

  always_comb begin
    new_item.weight  = in_ch.weight;
    new_item.xval[0] = in_ch.design_0;
    new_item.xval[1] = in_ch.design_1;
    new_item.xval[2] = in_ch.design_2;
    new_item.xval[3] = in_ch.design_3;
    new_item.xval[4] = in_ch.design_4;
    new_item.xval[5] = in_ch.design_5;
    new_item.xval[6] = in_ch.design_6;
    new_item.xval[7] = in_ch.design_7;
    new_item.last    = in_ch.last_sample;
    new_item.ncoef   = ncoef_cl;
  end

  assign in_ch.ready = (cnt_r != CNT_W'(QDEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign head.valid  = (cnt_r != '0);
  assign head.item   = q_mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_coefs_r <= NCOEF_W'(1);
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      cnt_r       <= '0;
    end else begin
      if (cfg_we) begin
        num_coefs_r <= cfg_wdata;
      end
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      cnt_r <= cnt_r + CNT_W'(push) - CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= new_item;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(QDEPTH)) else $error("queue count above depth");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head.valid) else $error("pop from empty queue");
  a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> cnt_r == $past(cnt_r) + CNT_W'(1))
    else $error("queue count lost a push");
endmodule

// File: rtl/wgma_back.sv
// Back end: pair sequencer, shared multiply-accumulate pipeline and entry emitter.
module wgma_back import wgma_pkg::*; #(
  parameter int MAX_COEFS = MAX_COEFS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  qhead_t     head,
  output logic       pop,
  wgma_out_if.source out_ch
);
  localparam int DEPTH = MAX_COEFS * (MAX_COEFS + 1) / 2;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_ACC   = 5'b00010,
    S_DRAIN = 5'b00100,
    S_ERD   = 5'b01000,
    S_EOUT  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  item_t  work_r, work_nxt;
  logic [POS_W-1:0] c_r, c_nxt, r_r, r_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [DEPTH-1:0] valid_r, valid_nxt;

  logic                    s1_vld_r, s2_vld_r;
  logic [IDX_W-1:0]        s1_idx_r, s2_idx_r;
  logic signed [31:0]      s1_prod_r;
  logic signed [SUM_W-1:0] s2_prod_r, s2_old_r;

  logic                    out_vld_r, out_vld_nxt;
  logic [POS_W-1:0]        out_row_r, out_col_r;
  logic signed [SUM_W-1:0] out_sum_r;
  logic                    out_last_r;

  logic               pair_end, matrix_end, can_load, load;
  logic signed [31:0] xx;
  logic signed [32:0] w_s;
  logic signed [65:0] mw;
  logic signed [SUM_W:0] sum_w;
  logic signed [SUM_W-1:0] sum_sat, old_val, ram_rdata;
  logic               rd_en;

  wgma_ram #(.WIDTH(SUM_W), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (s2_vld_r),
    .waddr (s2_idx_r),
    .wdata (sum_sat),
    .re    (rd_en),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  assign pair_end   = (r_r == c_r);
  assign matrix_end = pair_end && ({1'b0, c_r} + NCOEF_W'(1) == work_r.ncoef);
  assign rd_en      = (state_r == S_ACC) || (state_r == S_ERD);
  assign can_load   = !out_vld_r || out_ch.ready;
  assign load       = (state_r == S_EOUT) && can_load;

  // Product chain: design pair first, then the weight one stage later.
  assign xx  = $signed(work_r.xval[r_r]) * $signed(work_r.xval[c_r]);
  assign w_s = $signed({1'b0, work_r.weight});
  assign mw  = s1_prod_r * w_s;
  assign old_val = valid_r[s1_idx_r] ? ram_rdata : '0;

  always_comb begin
    sum_w = {s2_old_r[SUM_W-1], s2_old_r} + {s2_prod_r[SUM_W-1], s2_prod_r};
    if (sum_w[SUM_W] != sum_w[SUM_W-1]) begin
      sum_sat = sum_w[SUM_W] ? SUM_MIN : SUM_MAX;
    end else begin
      sum_sat = sum_w[SUM_W-1:0];
    end
  end

  always_comb begin
    state_nxt   = state_r;
    work_nxt    = work_r;
    c_nxt       = c_r;
    r_nxt       = r_r;
    idx_nxt     = idx_r;
    valid_nxt   = valid_r;
    pop         = 1'b0;
    out_vld_nxt = out_vld_r && !out_ch.ready;
    if (s2_vld_r) begin
      valid_nxt[s2_idx_r] = 1'b1;
    end
    unique case (state_r)
      S_IDLE: begin
        if (head.valid) begin
          pop       = 1'b1;
          work_nxt  = head.item;
          c_nxt     = '0;
          r_nxt     = '0;
          idx_nxt   = '0;
          state_nxt = S_ACC;
        end
      end
      S_ACC: begin
        idx_nxt = idx_r + IDX_W'(1);
        if (matrix_end) begin
          state_nxt = S_DRAIN;
        end else if (pair_end) begin
          c_nxt = c_r + POS_W'(1);
          r_nxt = '0;
        end else begin
          r_nxt = r_r + POS_W'(1);
        end
      end
      S_DRAIN: begin
        if (!s1_vld_r && !s2_vld_r) begin
          c_nxt     = '0;
          r_nxt     = '0;
          idx_nxt   = '0;
          state_nxt = work_r.last ? S_ERD : S_IDLE;
        end
      end
      S_ERD: begin
        state_nxt = S_EOUT;
      end
      S_EOUT: begin
        if (load) begin
          out_vld_nxt = 1'b1;
          idx_nxt     = idx_r + IDX_W'(1);
          if (matrix_end) begin
            valid_nxt = '0;
            state_nxt = S_IDLE;
          end else begin
            if (pair_end) begin
              c_nxt = c_r + POS_W'(1);
              r_nxt = '0;
            end else begin
              r_nxt = r_r + POS_W'(1);
            end
            state_nxt = S_ERD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      valid_r   <= '0;
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      c_r       <= '0;
      r_r       <= '0;
      idx_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      valid_r   <= valid_nxt;
      s1_vld_r  <= (state_r == S_ACC);
      s2_vld_r  <= s1_vld_r;
      out_vld_r <= out_vld_nxt;
      c_r       <= c_nxt;
      r_r       <= r_nxt;
      idx_r     <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    work_r    <= work_nxt;
    s1_prod_r <= xx;
    s1_idx_r  <= idx_r;
    s2_prod_r <= mw[SUM_W-1:0];
    s2_old_r  <= old_val;
    s2_idx_r  <= s1_idx_r;
    if (load) begin
      out_row_r  <= r_r;
      out_col_r  <= c_r;
      out_sum_r  <= valid_r[idx_r] ? ram_rdata : '0;
      out_last_r <= matrix_end;
    end
  end

  assign out_ch.valid      = out_vld_r;
  assign out_ch.row_index  = out_row_r;
  assign out_ch.col_index  = out_col_r;
  assign out_ch.sum_value  = out_sum_r;
  assign out_ch.last_entry = out_last_r;

  a_write_in_acc: assert property (@(posedge clk) disable iff (!rst_n)
    s2_vld_r |-> (state_r == S_ACC || state_r == S_DRAIN))
    else $error("accumulator write outside accumulation");
  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (!s1_vld_r && !s2_vld_r))
    else $error("pipeline busy while idle");
  a_row_le_col: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (out_row_r <= out_col_r)) else $error("row above column");
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (load && matrix_end) |=> (valid_r == '0))
    else $error("accumulators not cleared after last entry");
endmodule

// File: rtl/weighted_gram_matrix_accumulator_unit.sv
// Top level of the weighted Gram matrix (upper triangle of X'WX) accumulator.
// Usage: each word on in_ch is one sample: an unsigned Q16.16 weight, eight
// signed Q4.12 design values and a last-sample mark. For every pair row <= col
// among the active coefficients the block adds weight*design_row*design_col
// into a saturating signed Q24.40 accumulator. When a last sample has been
// added, the block sends every active entry on out_ch, ordered by column and
// then by row up to the diagonal, marks the final one with last_entry and
// clears all accumulators. cfg_we/cfg_wdata set the coefficient count n; a
// count of 0 acts as 1 and a count above MAX_COEFS acts as MAX_COEFS. The
// count is sampled when a sample word is accepted.
// Timing: the back end takes one sample at a time through a single shared
// multiply-accumulate pipeline, one pair per cycle. For a last sample, each
// emitted entry waits for its registered accumulator memory read and for any
// receiver stall. A two-word queue between intake and the back end keeps
// in_ch ready while earlier samples are still being processed.
// Reset: all accumulators read as zero, n is 1 and the queue is empty. When
// out_ch stalls, the pending entry holds in the output register and the
// emitter waits; intake continues until the queue is full.
module weighted_gram_matrix_accumulator_unit import wgma_pkg::*; #(
  parameter int MAX_COEFS = MAX_COEFS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [NCOEF_W-1:0] cfg_wdata,
  wgma_in_if.sink            in_ch,
  wgma_out_if.source         out_ch
);
  qhead_t head;
  logic   pop;

  // Front end registers the count and queues tagged sample words.
  wgma_front #(.MAX_COEFS(MAX_COEFS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .head      (head),
    .pop       (pop)
  );

  // Back end accumulates the pairs and emits the matrix on a last sample.
  wgma_back #(.MAX_COEFS(MAX_COEFS)) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .pop    (pop),
    .out_ch (out_ch)
  );
endmodule
